FILE: hw/rtl/mwkw_pkg.sv
// Shared constants, state codes and types for the max-weight key window block.
// No dependencies.
`timescale 1ns / 1ps

package mwkw_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int KEY_W     = 32;
    localparam int WT_W      = 32;
    localparam int TOT_W     = 42;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RD_I  = 6'b000010,
        ST_GET_I = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_FIN_I = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // Window membership flags from the compare unit.
    typedef struct packed {
        logic up_hit;
        logic down_hit;
    } span_hit_t;

endpackage

FILE: hw/rtl/mwkw_span_unit.sv
// Shared compare unit: tests whether one key lies within the window above
// or below the anchor key. Depends on mwkw_pkg.
`timescale 1ns / 1ps

module mwkw_span_unit (
    input  logic [mwkw_pkg::KEY_W-1:0] anchor_key,
    input  logic [mwkw_pkg::KEY_W-1:0] probe_key,
    input  logic [mwkw_pkg::KEY_W-1:0] width,
    output mwkw_pkg::span_hit_t        hit
);

    logic [mwkw_pkg::KEY_W:0] diff_up;
    logic [mwkw_pkg::KEY_W:0] diff_down;

    // A borrow in the top bit means the probe is on the other side.
    always_comb
    begin
        diff_up      = {1'b0, probe_key} - {1'b0, anchor_key};
        diff_down    = {1'b0, anchor_key} - {1'b0, probe_key};
        hit.up_hit   = !diff_up[mwkw_pkg::KEY_W]
                       && (diff_up[mwkw_pkg::KEY_W-1:0] < width);
        hit.down_hit = !diff_down[mwkw_pkg::KEY_W]
                       && (diff_down[mwkw_pkg::KEY_W-1:0] < width);
    end

endmodule

FILE: hw/rtl/max_weight_key_window.sv
// Top level of the max-weight key window block: item store and scan sequencer.
// Depends on mwkw_pkg and mwkw_span_unit.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------
// item in   | in        | start, busy          | item_key, item_weight, last_item
// result    | out       | done (one cycle)     | best_total
// config    | in        | cfg_valid, cfg_ready | cfg_data (window width)
//
// Items are stored at one per cycle while busy is low. After the last item
// the block scans all n stored items against each other through one shared
// compare unit, one anchor item at a time, then shows the result for one
// cycle on done. Reset is asynchronous and clears the sequencer, the item
// count and the window width (to 1). The receiver cannot stall; items
// beyond the store depth are dropped.

module max_weight_key_window (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mwkw_pkg::KEY_W-1:0]    item_key,
    input  logic [mwkw_pkg::WT_W-1:0]     item_weight,
    input  logic                          last_item,
    output logic                          done,
    output logic [mwkw_pkg::TOT_W-1:0]    best_total,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mwkw_pkg::KEY_W-1:0]    cfg_data
);

    mwkw_pkg::state_t state_reg, state_next;

    logic [mwkw_pkg::KEY_W-1:0]  key_mem [mwkw_pkg::MAX_ITEMS];
    logic [mwkw_pkg::WT_W-1:0]   wt_mem  [mwkw_pkg::MAX_ITEMS];
    logic [mwkw_pkg::KEY_W-1:0]  key_rd_reg;
    logic [mwkw_pkg::WT_W-1:0]   wt_rd_reg;
    logic [mwkw_pkg::ADDR_W-1:0] rd_addr;

    logic [mwkw_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [mwkw_pkg::CNT_W-1:0]  n_reg, n_next;
    logic [mwkw_pkg::ADDR_W-1:0] i_reg, i_next;
    logic [mwkw_pkg::ADDR_W-1:0] j_reg, j_next;
    logic [mwkw_pkg::KEY_W-1:0]  anchor_reg, anchor_next;
    logic [mwkw_pkg::KEY_W-1:0]  width_reg;
    logic [mwkw_pkg::TOT_W-1:0]  up_reg, up_next;
    logic [mwkw_pkg::TOT_W-1:0]  down_reg, down_next;
    logic [mwkw_pkg::TOT_W-1:0]  best_reg, best_next;

    logic                        accept;
    logic                        store_en;
    logic [mwkw_pkg::CNT_W-1:0]  n_last;
    mwkw_pkg::span_hit_t         hit;

    assign busy       = (state_reg != mwkw_pkg::ST_IDLE);
    assign cfg_ready  = !busy;
    assign accept     = start && !busy;
    assign store_en   = accept
                        && (count_reg < mwkw_pkg::CNT_W'(mwkw_pkg::MAX_ITEMS));
    assign done       = (state_reg == mwkw_pkg::ST_DONE);
    assign best_total = best_reg;
    assign n_last     = n_reg - mwkw_pkg::CNT_W'(1);

    // Shared compare unit.
    mwkw_span_unit u_span (
        .anchor_key (anchor_reg),
        .probe_key  (key_rd_reg),
        .width      (width_reg),
        .hit        (hit)
    );

    // Item store, written on load and read one entry per cycle.
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            key_mem[count_reg[mwkw_pkg::ADDR_W-1:0]] <= item_key;
            wt_mem[count_reg[mwkw_pkg::ADDR_W-1:0]]  <= item_weight;
        end
        key_rd_reg <= key_mem[rd_addr];
        wt_rd_reg  <= wt_mem[rd_addr];
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        anchor_next = anchor_reg;
        up_next     = up_reg;
        down_next   = down_reg;
        best_next   = best_reg;
        rd_addr     = j_reg + mwkw_pkg::ADDR_W'(1);
        case (state_reg)
            mwkw_pkg::ST_IDLE:
            begin
                if (store_en)
                begin
                    count_next = count_reg + mwkw_pkg::CNT_W'(1);
                end
                if (accept && last_item)
                begin
                    n_next     = store_en ? count_reg + mwkw_pkg::CNT_W'(1) : count_reg;
                    count_next = '0;
                    i_next     = '0;
                    best_next  = '0;
                    state_next = mwkw_pkg::ST_RD_I;
                end
            end
            mwkw_pkg::ST_RD_I:
            begin
                rd_addr    = i_reg;
                state_next = mwkw_pkg::ST_GET_I;
            end
            mwkw_pkg::ST_GET_I:
            begin
                rd_addr     = '0;
                anchor_next = key_rd_reg;
                j_next      = '0;
                up_next     = '0;
                down_next   = '0;
                state_next  = mwkw_pkg::ST_SCAN;
            end
            mwkw_pkg::ST_SCAN:
            begin
                // Entry j is in the read register; accumulate its weight.
                if (hit.up_hit)
                begin
                    up_next = up_reg + mwkw_pkg::TOT_W'(wt_rd_reg);
                end
                if (hit.down_hit)
                begin
                    down_next = down_reg + mwkw_pkg::TOT_W'(wt_rd_reg);
                end
                j_next = j_reg + mwkw_pkg::ADDR_W'(1);
                if ({1'b0, j_reg} == n_last)
                begin
                    state_next = mwkw_pkg::ST_FIN_I;
                end
            end
            mwkw_pkg::ST_FIN_I:
            begin
                if (up_reg > best_reg && up_reg >= down_reg)
                begin
                    best_next = up_reg;
                end
                else if (down_reg > best_reg)
                begin
                    best_next = down_reg;
                end
                i_next = i_reg + mwkw_pkg::ADDR_W'(1);
                if ({1'b0, i_reg} == n_last)
                begin
                    state_next = mwkw_pkg::ST_DONE;
                end
                else
                begin
                    state_next = mwkw_pkg::ST_RD_I;
                end
            end
            mwkw_pkg::ST_DONE:
            begin
                state_next = mwkw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mwkw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwkw_pkg::ST_IDLE;
            count_reg <= '0;
            width_reg <= mwkw_pkg::KEY_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        anchor_reg <= anchor_next;
        up_reg     <= up_next;
        down_reg   <= down_next;
        best_reg   <= best_next;
    end

endmodule
